### src/mask_run_length_decoder_unit_defines.svh
// Assertion macros shared by the mask run-length decoder RTL.
`ifndef MASK_RUN_LENGTH_DECODER_UNIT_DEFINES_SVH
`define MASK_RUN_LENGTH_DECODER_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define MRLD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define MRLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mrld_pkg.sv
// Types and constants of the mask run-length decoder.
package mrld_pkg;

    localparam logic [7:0] SIG_ROWS     = 8'h68;
    localparam logic [7:0] SIG_COLS     = 8'h76;
    localparam logic [7:0] LINE_MARK    = 8'hFF;
    localparam logic [2:0] HEADER_BYTES = 3'd5;

    localparam int COORD_W = 9;
    localparam int TOTAL_W = 16;
    localparam int TDATA_W = 56;

    // Result queue: four entries, two-bit pointers.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;

    // Field slots of the header after the signature.
    localparam logic [1:0] FLD_X      = 2'd0;
    localparam logic [1:0] FLD_Y      = 2'd1;
    localparam logic [1:0] FLD_WIDTH  = 2'd2;
    localparam logic [1:0] FLD_HEIGHT = 2'd3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_SIG   = 3'd2,
        ST_ZERO_SIZE = 3'd3,
        ST_NO_RUNS   = 3'd4
    } status_t;

    typedef enum logic {
        KIND_RECT    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [COORD_W-1:0]   left;
        logic [COORD_W-1:0]   top;
        logic [COORD_W-1:0]   right;
        logic [COORD_W-1:0]   bottom;
        status_t              status;
        logic [TOTAL_W-1:0]   total;
        logic                 last;
    } item_t;

endpackage

### src/mask_run_length_decoder_unit.sv
// Mask run-length decoder: byte stream in, run rectangles and a summary item out.
//
// Slave side takes one byte of the coded mask per item (s_tdata), with s_tlast
// on the final byte of a stream. Master side gives run rectangles
// (m_tuser = 0) and one closing summary item per stream (m_tuser = 1,
// m_tlast = 1) carrying bounding box, status and rectangle count.
// Throughput: one byte per cycle while s_tready is high. Each byte yields at most
// two items; the byte that carries s_tlast may yield a rectangle and the
// summary, which then leave one after the other.
// An item produced by an accepted byte is registered in the queue and is on
// m_ once those ahead of it have gone.
// The decode state sits in registers updated in the accept cycle; results go
// to a four-entry queue, and s_tready is high while at most two entries hold.
// When the receiver stalls the queue fills and s_tready drops; nothing is
// lost. Reset (aresetn low, synchronous) empties the queue and returns the
// decoder to the start of a header. After the summary item the decoder is
// back in that state for the next stream.
module mask_run_length_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [mrld_pkg::TDATA_W-1:0] m_tdata, // [8:0] left, [17:9] top, [26:18] right,
                                                  // [35:27] bottom, [38:36] status,
                                                  // [54:39] rect_total, [55] zero
    output logic        m_tuser,   // [0] item_kind
    output logic        m_tlast
);

`include "mask_run_length_decoder_unit_defines.svh"

    localparam int CW = mrld_pkg::COORD_W;

    // Decode state
    logic [2:0]              pos_reg, pos_next;
    logic                    rows_reg, rows_next;
    logic [7:0]              fld_reg [4];
    logic [7:0]              fld_next [4];
    logic [7:0]              line_reg, line_next;
    logic [7:0]              start_reg, start_next;
    logic                    have_reg, have_next;
    mrld_pkg::status_t       err_reg, err_next;
    logic [15:0]             cnt_reg, cnt_next;

    // Result queue
    mrld_pkg::item_t                 q_mem [mrld_pkg::QUEUE_DEPTH];
    logic [mrld_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [mrld_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [mrld_pkg::CNT_W-1:0]      q_cnt_reg, q_cnt_next;

    logic acc, pop;

    // Values after this byte, before the end-of-stream clear
    logic [2:0]              pos_upd;
    logic                    rows_upd;
    logic [7:0]              fld_upd [4];
    logic [7:0]              line_upd, start_upd;
    logic                    have_upd;
    mrld_pkg::status_t       err_upd;
    logic [15:0]             cnt_upd;

    logic [1:0]              fld_idx;
    logic [7:0]              line_ext, run_ext;
    logic [CW-1:0]           run_lo, run_hi, run_sum, line_lo, line_hi;
    logic                    rect_valid, sum_valid;
    mrld_pkg::item_t         rect_item, sum_item;
    mrld_pkg::status_t       sum_status;
    mrld_pkg::item_t         head;

    assign acc      = s_tvalid & s_tready;
    assign pop      = m_tvalid & m_tready;
    assign s_tready = (q_cnt_reg <= mrld_pkg::CNT_W'(mrld_pkg::QUEUE_DEPTH - 2));

    assign fld_idx  = 2'(pos_reg - 3'd1);
    assign line_ext = rows_reg ? fld_reg[mrld_pkg::FLD_HEIGHT] : fld_reg[mrld_pkg::FLD_WIDTH];
    assign run_ext  = rows_reg ? fld_reg[mrld_pkg::FLD_WIDTH] : fld_reg[mrld_pkg::FLD_HEIGHT];

    // Run span clipped to the run extent
    assign run_lo  = {1'b0, start_reg};
    assign run_sum = {1'b0, start_reg} + {1'b0, s_tdata};
    assign run_hi  = (run_sum > {1'b0, run_ext}) ? {1'b0, run_ext} : run_sum;
    assign line_lo = {1'b0, line_reg};
    assign line_hi = {1'b0, line_reg} + 9'd1;

    always_comb begin
        pos_upd    = pos_reg;
        rows_upd   = rows_reg;
        fld_upd    = fld_reg;
        line_upd   = line_reg;
        start_upd  = start_reg;
        have_upd   = have_reg;
        err_upd    = err_reg;
        cnt_upd    = cnt_reg;
        rect_valid = 1'b0;

        rect_item        = '0;
        rect_item.kind   = mrld_pkg::KIND_RECT;
        rect_item.status = mrld_pkg::ST_OK;
        if (rows_reg) begin
            rect_item.left   = {1'b0, fld_reg[mrld_pkg::FLD_X]} + run_lo;
            rect_item.right  = {1'b0, fld_reg[mrld_pkg::FLD_X]} + run_hi;
            rect_item.top    = {1'b0, fld_reg[mrld_pkg::FLD_Y]} + line_lo;
            rect_item.bottom = {1'b0, fld_reg[mrld_pkg::FLD_Y]} + line_hi;
        end else begin
            rect_item.left   = {1'b0, fld_reg[mrld_pkg::FLD_X]} + line_lo;
            rect_item.right  = {1'b0, fld_reg[mrld_pkg::FLD_X]} + line_hi;
            rect_item.top    = {1'b0, fld_reg[mrld_pkg::FLD_Y]} + run_lo;
            rect_item.bottom = {1'b0, fld_reg[mrld_pkg::FLD_Y]} + run_hi;
        end

        if (pos_reg == 3'd0) begin
            rows_upd = (s_tdata == mrld_pkg::SIG_ROWS);
            err_upd  = (s_tdata == mrld_pkg::SIG_ROWS || s_tdata == mrld_pkg::SIG_COLS)
                       ? mrld_pkg::ST_OK : mrld_pkg::ST_BAD_SIG;
            pos_upd  = 3'd1;
        end else if (pos_reg < mrld_pkg::HEADER_BYTES) begin
            fld_upd[fld_idx] = s_tdata;
            pos_upd          = pos_reg + 3'd1;
            // height arrives last; width is already stored
            if (pos_reg == mrld_pkg::HEADER_BYTES - 3'd1 && err_reg == mrld_pkg::ST_OK &&
                (fld_reg[mrld_pkg::FLD_WIDTH] == 8'd0 || s_tdata == 8'd0)) begin
                err_upd = mrld_pkg::ST_ZERO_SIZE;
            end
        end else if (err_reg == mrld_pkg::ST_OK && line_reg < line_ext) begin
            if (have_reg) begin
                have_upd = 1'b0;
                if (start_reg < run_ext && s_tdata != 8'd0) begin
                    rect_valid = 1'b1;
                    if (cnt_reg != 16'hFFFF) begin
                        cnt_upd = cnt_reg + 16'd1;
                    end
                end
            end else if (!s_tlast) begin
                if (s_tdata == mrld_pkg::LINE_MARK) begin
                    line_upd = line_reg + 8'd1;
                end else begin
                    start_upd = s_tdata;
                    have_upd  = 1'b1;
                end
            end
        end

        // Closing summary
        sum_valid = s_tlast;
        if (pos_upd < mrld_pkg::HEADER_BYTES) begin
            sum_status = mrld_pkg::ST_SHORT;
        end else if (err_upd != mrld_pkg::ST_OK) begin
            sum_status = err_upd;
        end else if (cnt_upd == 16'd0) begin
            sum_status = mrld_pkg::ST_NO_RUNS;
        end else begin
            sum_status = mrld_pkg::ST_OK;
        end
        sum_item        = '0;
        sum_item.kind   = mrld_pkg::KIND_SUMMARY;
        sum_item.status = sum_status;
        sum_item.total  = cnt_upd;
        sum_item.last   = 1'b1;
        if (sum_status == mrld_pkg::ST_OK || sum_status == mrld_pkg::ST_NO_RUNS) begin
            sum_item.left   = {1'b0, fld_upd[mrld_pkg::FLD_X]};
            sum_item.top    = {1'b0, fld_upd[mrld_pkg::FLD_Y]};
            sum_item.right  = {1'b0, fld_upd[mrld_pkg::FLD_X]} +
                              {1'b0, fld_upd[mrld_pkg::FLD_WIDTH]};
            sum_item.bottom = {1'b0, fld_upd[mrld_pkg::FLD_Y]} +
                              {1'b0, fld_upd[mrld_pkg::FLD_HEIGHT]};
        end
    end

    // State update; end of stream returns to the header start
    always_comb begin
        pos_next   = pos_reg;
        rows_next  = rows_reg;
        fld_next   = fld_reg;
        line_next  = line_reg;
        start_next = start_reg;
        have_next  = have_reg;
        err_next   = err_reg;
        cnt_next   = cnt_reg;
        if (acc) begin
            if (s_tlast) begin
                pos_next   = 3'd0;
                rows_next  = 1'b0;
                fld_next   = '{default: 8'd0};
                line_next  = 8'd0;
                start_next = 8'd0;
                have_next  = 1'b0;
                err_next   = mrld_pkg::ST_OK;
                cnt_next   = 16'd0;
            end else begin
                pos_next   = pos_upd;
                rows_next  = rows_upd;
                fld_next   = fld_upd;
                line_next  = line_upd;
                start_next = start_upd;
                have_next  = have_upd;
                err_next   = err_upd;
                cnt_next   = cnt_upd;
            end
        end
    end

    // Queue pointers
    always_comb begin
        logic [mrld_pkg::CNT_W-1:0] n_push;
        n_push = '0;
        if (acc) begin
            n_push = mrld_pkg::CNT_W'(rect_valid) + mrld_pkg::CNT_W'(sum_valid);
        end
        wr_ptr_next = wr_ptr_reg + mrld_pkg::PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + mrld_pkg::PTR_W'(pop);
        q_cnt_next  = q_cnt_reg + n_push - mrld_pkg::CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= 3'd0;
            rows_reg   <= 1'b0;
            fld_reg    <= '{default: 8'd0};
            line_reg   <= 8'd0;
            start_reg  <= 8'd0;
            have_reg   <= 1'b0;
            err_reg    <= mrld_pkg::ST_OK;
            cnt_reg    <= 16'd0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end else begin
            pos_reg    <= pos_next;
            rows_reg   <= rows_next;
            fld_reg    <= fld_next;
            line_reg   <= line_next;
            start_reg  <= start_next;
            have_reg   <= have_next;
            err_reg    <= err_next;
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    // Queue payload; the rectangle goes ahead of the summary
    always_ff @(posedge aclk) begin
        if (acc) begin
            if (rect_valid) begin
                q_mem[wr_ptr_reg] <= rect_item;
                if (sum_valid) begin
                    q_mem[wr_ptr_reg + mrld_pkg::PTR_W'(1)] <= sum_item;
                end
            end else if (sum_valid) begin
                q_mem[wr_ptr_reg] <= sum_item;
            end
        end
    end

    assign head     = q_mem[rd_ptr_reg];
    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tdata  = {1'b0, head.total, head.status, head.bottom, head.right,
                       head.top, head.left};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    `MRLD_ASSERT(a_queue_bound, q_cnt_reg <= mrld_pkg::CNT_W'(mrld_pkg::QUEUE_DEPTH), "result queue overflow")
    `MRLD_ASSERT(a_kind_last, !m_tvalid || (m_tlast == m_tuser), "summary kind and tlast disagree")
    `MRLD_ASSERT(a_rect_status, !m_tvalid || m_tuser || (m_tdata[38:36] == 3'd0), "rectangle carries status")
    `MRLD_ASSERT_NEXT(a_eos_clear, acc && s_tlast, pos_reg == 3'd0 && cnt_reg == 16'd0 && m_tvalid, "stream end did not restart decoder")

endmodule
